[rtl/msfv_pkg.sv]
`timescale 1ns / 1ps
package msfv_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegEnableMask = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStepsPerRev = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLoadThreshold = 2'd2;

  localparam logic [15:0] StepsPerRevReset = 16'd3200;
  localparam logic [15:0] SlowLimit16 = 16'd3200;
  localparam logic [1:0] TripCount = 2'd3;
  localparam logic [7:0] ArmCount = 8'd5;

  typedef struct packed {
    logic [1:0]         motor_index;
    logic [31:0]        pulse_count;
    logic signed [31:0] step_position;
    logic [23:0]        period_us;
    logic [15:0]        speed_rpm16;
    logic               profile_valid;
    logic [23:0]        profile_mean_us;
    logic [23:0]        profile_sigma_us;
    logic [9:0]         stall_load;
  } poll_t;

  typedef struct packed {
    logic [1:0]         motor_out;
    logic               evaluated;
    logic [2:0]         fault_code;
    logic [1:0]         error_count;
    logic [7:0]         settle_count;
    logic               armed;
    logic               tripped;
    logic               stop_request;
    logic signed [31:0] delta_per_pulse;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input poll
    logic div_start; // start divider
    logic div_step;  // one quotient bit
    logic finish;    // apply update and build result
    logic no_effect; // build a pass-through result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic effect;   // motor on and new pulse
    logic div_done;
  } status_t;

endpackage

[rtl/msfv_if.sv]
`timescale 1ns / 1ps
interface msfv_poll_if;
  logic valid;
  logic ready;
  msfv_pkg::poll_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface msfv_result_if;
  logic valid;
  logic ready;
  msfv_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/msfv_ctrl.sv]
`timescale 1ns / 1ps
module msfv_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  msfv_pkg::status_t  status_i,
  output msfv_pkg::cmd_t     cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCheck = 2'd1;
  localparam logic [1:0] StDiv = 2'd2;
  localparam logic [1:0] StFinish = 2'd3;

  logic [1:0] state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // result register may be full while the next poll is taken
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (status_i.effect) begin
          cmd_o.div_start = 1'b1;
          state_d = StDiv;
        end else if (out_free) begin
          cmd_o.no_effect = 1'b1;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      StDiv: begin
        if (status_i.div_done) state_d = StFinish;
        else cmd_o.div_step = 1'b1;
      end
      StFinish: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/msfv_datapath.sv]
`timescale 1ns / 1ps
module msfv_datapath #(
  parameter int unsigned MOTORS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [msfv_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [msfv_pkg::CfgDataW-1:0]  cfg_data_i,
  input  msfv_pkg::poll_t                poll_i,
  input  msfv_pkg::cmd_t                 cmd_i,
  output msfv_pkg::status_t              status_o,
  output msfv_pkg::result_t              result_o
);

  localparam int unsigned MW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  logic [3:0]  enable_q;
  logic [15:0] spr_q;
  logic [9:0]  thr_q;

  logic [31:0] last_pulse_q [MOTORS];
  logic [31:0] last_pos_q [MOTORS];
  logic [15:0] armed_speed_q [MOTORS];
  logic [MOTORS-1:0] pending_q, active_q, trip_q;
  logic [1:0]  fault_run_q [MOTORS];
  logic [7:0]  clean_run_q [MOTORS];
  logic [2:0]  last_code_q [MOTORS];

  msfv_pkg::poll_t poll_q;
  msfv_pkg::result_t res_q;

  logic          valid_idx, on;
  logic [MW-1:0] m;
  logic [31:0]   np, total;

  // divider: restoring, one quotient bit per cycle on magnitudes
  logic [31:0] dvd_q, dvs_q, quo_q;
  logic [32:0] rem_q;
  logic [5:0]  cnt_q;
  logic        neg_q;
  logic [32:0] rem_sh, rem_sub;

  assign valid_idx = {30'd0, poll_q.motor_index} < 32'(MOTORS);
  assign m = MW'(poll_q.motor_index);
  assign on = valid_idx && enable_q[poll_q.motor_index];
  assign np = poll_q.pulse_count - last_pulse_q[m];
  assign total = poll_q.step_position - last_pos_q[m];
  assign status_o.effect = on && (np != 32'd0);
  assign status_o.div_done = (cnt_q == 6'd32);
  assign rem_sh = {rem_q[31:0], dvd_q[31]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign result_o = res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) poll_q <= poll_i;
    if (cmd_i.div_start) begin
      dvd_q <= total[31] ? (32'd0 - total) : total;
      dvs_q <= np[31] ? (32'd0 - np) : np;
      neg_q <= total[31] ^ np[31];
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      if (!rem_sub[32]) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[30:0], 1'b0};
      end
      cnt_q <= cnt_q + 6'd1;
    end
  end

  // finish-phase evaluation
  logic signed [31:0] delta;
  logic [24:0] pdiff;
  logic [25:0] lhs_a;
  logic [26:0] rhs_a;
  logic [31:0] mag_d;
  logic [32:0] bdiff;
  logic        ea, eb, ec, fault, slow;
  logic [15:0] sd;
  logic [19:0] sd10;
  logic        disarm, act0;
  logic [1:0]  fr_n;
  logic [7:0]  cr_n;
  logic        act_n, trip_n, stop_n;
  logic [15:0] as_n;
  logic [2:0]  lc_n;
  logic        pend_n, eval_n;

  always_comb begin
    if (!neg_q) delta = (quo_q[31]) ? 32'sh7FFFFFFF : $signed(quo_q);
    else delta = $signed(32'd0 - quo_q);
    pdiff = (poll_q.period_us >= poll_q.profile_mean_us)
      ? 25'(poll_q.period_us - poll_q.profile_mean_us)
      : 25'(poll_q.profile_mean_us - poll_q.period_us);
    lhs_a = {pdiff, 1'b0};
    rhs_a = 27'(poll_q.profile_sigma_us) * 27'd7;
    ea = poll_q.profile_valid && ({1'b0, lhs_a} > rhs_a);
    mag_d = delta[31] ? (32'd0 - delta) : delta;
    bdiff = ({1'b0, mag_d} >= {17'd0, spr_q}) ? ({1'b0, mag_d} - {17'd0, spr_q})
      : ({17'd0, spr_q} - {1'b0, mag_d});
    eb = (spr_q != 16'd0) && (bdiff > {20'd0, spr_q[15:3]});
    ec = (thr_q != 10'd0) && (poll_q.stall_load < thr_q);
    fault = (32'(ea) + 32'(eb) + 32'(ec)) >= 32'd2;
    slow = poll_q.speed_rpm16 < msfv_pkg::SlowLimit16;
    sd = (poll_q.speed_rpm16 >= armed_speed_q[m]) ? poll_q.speed_rpm16 - armed_speed_q[m]
      : armed_speed_q[m] - poll_q.speed_rpm16;
    sd10 = 20'(sd) * 20'd10;
    disarm = active_q[m] && (sd10 > 20'(armed_speed_q[m]));

    fr_n = fault_run_q[m];
    cr_n = clean_run_q[m];
    act_n = active_q[m];
    trip_n = trip_q[m];
    as_n = armed_speed_q[m];
    lc_n = last_code_q[m];
    pend_n = pending_q[m];
    stop_n = 1'b0;
    eval_n = 1'b0;
    act0 = act_n;
    if (pending_q[m]) begin
      pend_n = 1'b0;
    end else if (slow) begin
      cr_n = '0;
    end else begin
      eval_n = 1'b1;
      if (disarm) begin
        act_n = 1'b0;
        cr_n = '0;
        fr_n = '0;
        as_n = '0;
      end
      act0 = act_n;
      if (fault) begin
        if (act0) begin
          if (fr_n < 2'd3) fr_n = fr_n + 2'd1;
          lc_n = {ea, eb, ec};
          if (fr_n >= msfv_pkg::TripCount) begin
            trip_n = 1'b1;
            act_n = 1'b0;
            stop_n = 1'b1;
          end
        end
        cr_n = '0;
      end else begin
        fr_n = '0;
        if (cr_n != 8'd255) cr_n = cr_n + 8'd1;
        if (!act0 && cr_n >= msfv_pkg::ArmCount) begin
          act_n = 1'b1;
          trip_n = 1'b0;
          as_n = poll_q.speed_rpm16;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish || cmd_i.no_effect) begin
      res_q.motor_out <= poll_q.motor_index;
      res_q.stop_request <= cmd_i.finish && stop_n;
      res_q.evaluated <= cmd_i.finish && eval_n;
      res_q.fault_code <= (cmd_i.finish && eval_n) ? {ea, eb, ec} : 3'd0;
      res_q.delta_per_pulse <= cmd_i.finish ? delta : 32'sd0;
      if (!valid_idx) begin
        res_q.error_count <= '0;
        res_q.settle_count <= '0;
        res_q.armed <= 1'b0;
        res_q.tripped <= 1'b0;
      end else if (cmd_i.finish) begin
        res_q.error_count <= fr_n;
        res_q.settle_count <= cr_n;
        res_q.armed <= act_n;
        res_q.tripped <= trip_n;
      end else begin
        res_q.error_count <= fault_run_q[m];
        res_q.settle_count <= clean_run_q[m];
        res_q.armed <= active_q[m];
        res_q.tripped <= trip_q[m];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      spr_q <= msfv_pkg::StepsPerRevReset;
      thr_q <= '0;
      pending_q <= '1;
      active_q <= '0;
      trip_q <= '0;
      for (int i = 0; i < MOTORS; i++) begin
        last_pulse_q[i] <= '0;
        last_pos_q[i] <= '0;
        armed_speed_q[i] <= '0;
        fault_run_q[i] <= '0;
        clean_run_q[i] <= '0;
        last_code_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        msfv_pkg::RegEnableMask: begin
          enable_q <= cfg_data_i[3:0];
          pending_q <= '1;
          for (int i = 0; i < MOTORS; i++) begin
            if (i >= 4 || !cfg_data_i[i%4]) begin
              active_q[i] <= 1'b0;
              trip_q[i] <= 1'b0;
              fault_run_q[i] <= '0;
              clean_run_q[i] <= '0;
              last_code_q[i] <= '0;
            end
          end
        end
        msfv_pkg::RegStepsPerRev: spr_q <= cfg_data_i;
        msfv_pkg::RegLoadThreshold: thr_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end else begin
      if (cmd_i.div_start) begin
        last_pulse_q[m] <= poll_q.pulse_count;
        last_pos_q[m] <= poll_q.step_position;
      end
      if (cmd_i.finish) begin
        fault_run_q[m] <= fr_n;
        clean_run_q[m] <= cr_n;
        active_q[m] <= act_n;
        trip_q[m] <= trip_n;
        armed_speed_q[m] <= as_n;
        last_code_q[m] <= lc_n;
        pending_q[m] <= pend_n;
      end
    end
  end

endmodule

[rtl/motor_stall_fault_voter_top.sv]
`timescale 1ns / 1ps
// Per-motor stall watchdog.
// poll_if (sink): one poll of one motor per transaction, valid/ready.
// result_if (source): exactly one result per poll, in poll order.
// Config: cfg_we_i/cfg_idx_i/cfg_data_i writes enable_mask (0),
// steps_per_rev (1), load_threshold (2); write only while idle.
// Flow: a poll without effect (motor disabled or no new pulse) gives its
// result from the check state; a poll with a new pulse first runs the
// 32-step serial divider computing steps per pulse, then the finish state.
// The block takes one poll at a time. The next poll is taken as soon
// as the previous result sits in the output register.
// When the receiver stalls, the result is held and the finishing poll waits
// until the output register frees.
// Reset: all motors disabled, baseline pending, counters and flags cleared,
// steps_per_rev 3200.
module motor_stall_fault_voter_top #(
  parameter int unsigned MOTORS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [msfv_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [msfv_pkg::CfgDataW-1:0] cfg_data_i,
  msfv_poll_if.sink                     poll_if,
  msfv_result_if.source                 result_if
);

  msfv_pkg::cmd_t    cmd;
  msfv_pkg::status_t status;

  msfv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (poll_if.valid),
    .in_ready_o  (poll_if.ready),
    .out_valid_o (result_if.valid),
    .out_ready_i (result_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  msfv_datapath #(.MOTORS(MOTORS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .poll_i     (poll_if.data),
    .cmd_i      (cmd),
    .status_o   (status),
    .result_o   (result_if.data)
  );

endmodule

[tb/sv/motor_stall_fault_voter_top_tb.sv]
`timescale 1ns / 1ps
module motor_stall_fault_voter_top_tb;

  localparam int unsigned NMot = 4;
  localparam logic [msfv_pkg::CfgIdxW-1:0] RegSpare = 2'd3;  // no register here, writes ignored
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned WatchLimit = 3000;
  localparam int unsigned NumRandom = 1550;
  localparam logic [15:0] SprSet [6] = '{16'd3200, 16'd0, 16'hFFFF, 16'd1, 16'd200, 16'd3200};
  localparam logic [9:0]  ThrSet [6] = '{10'd0, 10'h3FF, 10'd100, 10'd1, 10'd500, 10'd100};

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [msfv_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [msfv_pkg::CfgDataW-1:0] cfg_data_i;

  msfv_poll_if poll_if ();
  msfv_result_if result_if ();

  motor_stall_fault_voter_top #(.MOTORS(NMot)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .poll_if(poll_if),
    .result_if(result_if)
  );

  // watchdog model: configuration and per-motor state
  logic [3:0]  en_mask;
  logic [15:0] spr_reg;
  logic [9:0]  thresh_reg;
  logic [31:0] last_pulse [NMot];
  logic [31:0] last_pos [NMot];
  logic [15:0] armed_spd [NMot];
  bit          base_pend [NMot];
  bit          armed_f [NMot];
  bit          trip_f [NMot];
  logic [1:0]  fault_run [NMot];
  logic [7:0]  clean_run [NMot];

  msfv_pkg::result_t expected_q[$];
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  bit          quiet;

  // stimulus-side shadow of each motor's counters for well-formed sequences
  logic [31:0] trk_pulse [NMot];
  logic [31:0] trk_pos [NMot];
  logic [15:0] trk_speed [NMot];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void reset_model();
    en_mask = '0;
    spr_reg = msfv_pkg::StepsPerRevReset;
    thresh_reg = '0;
    for (int m = 0; m < NMot; m++) begin
      last_pulse[m] = '0;
      last_pos[m] = '0;
      armed_spd[m] = '0;
      base_pend[m] = 1'b1;
      armed_f[m] = 1'b0;
      trip_f[m] = 1'b0;
      fault_run[m] = '0;
      clean_run[m] = '0;
    end
  endfunction

  function automatic void apply_reg(logic [msfv_pkg::CfgIdxW-1:0] idx,
                                    logic [msfv_pkg::CfgDataW-1:0] val);
    case (idx)
      msfv_pkg::RegEnableMask: begin
        en_mask = val[3:0];
        for (int m = 0; m < NMot; m++) begin
          base_pend[m] = 1'b1;
          if (!en_mask[m]) begin
            armed_f[m] = 1'b0;
            trip_f[m] = 1'b0;
            fault_run[m] = '0;
            clean_run[m] = '0;
          end
        end
      end
      msfv_pkg::RegStepsPerRev: spr_reg = val;
      msfv_pkg::RegLoadThreshold: thresh_reg = val[9:0];
      default: ;
    endcase
  endfunction

  function automatic msfv_pkg::result_t vote(msfv_pkg::poll_t p);
    msfv_pkg::result_t r;
    int unsigned m;
    logic [31:0] np;
    longint total, dv, q, spr;
    bit ea, eb, ec;
    int n;
    r = '0;
    m = 32'(p.motor_index);
    r.motor_out = p.motor_index;
    if (en_mask[m]) begin
      np = p.pulse_count - last_pulse[m];
      if (np != 0) begin
        total = longint'($signed(p.step_position - last_pos[m]));
        dv = longint'($signed(np));
        last_pulse[m] = p.pulse_count;
        last_pos[m] = p.step_position;
        q = total / dv;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        r.delta_per_pulse = q[31:0];
        if (base_pend[m]) begin
          base_pend[m] = 1'b0;
        end else if (p.speed_rpm16 < msfv_pkg::SlowLimit16) begin
          clean_run[m] = '0;
        end else begin
          if (armed_f[m] &&
              mag(longint'(p.speed_rpm16) - longint'(armed_spd[m])) * 10 >
              longint'(armed_spd[m])) begin
            armed_f[m] = 1'b0;
            clean_run[m] = '0;
            fault_run[m] = '0;
            armed_spd[m] = '0;
          end
          spr = longint'(spr_reg);
          ea = p.profile_valid && 2 * mag(longint'(p.period_us) - longint'(p.profile_mean_us))
               > 7 * longint'(p.profile_sigma_us);
          eb = spr > 0 && mag(mag(q) - spr) > spr / 8;
          ec = thresh_reg != 0 && p.stall_load < thresh_reg;
          n = int'(ea) + int'(eb) + int'(ec);
          r.fault_code = {ea, eb, ec};
          r.evaluated = 1'b1;
          if (n >= 2) begin
            if (armed_f[m]) begin
              if (fault_run[m] < msfv_pkg::TripCount) fault_run[m]++;
              if (fault_run[m] >= msfv_pkg::TripCount) begin
                trip_f[m] = 1'b1;
                armed_f[m] = 1'b0;
                r.stop_request = 1'b1;
              end
            end
            clean_run[m] = '0;
          end else begin
            fault_run[m] = '0;
            if (clean_run[m] != 8'd255) clean_run[m]++;
            if (!armed_f[m] && clean_run[m] >= msfv_pkg::ArmCount) begin
              armed_f[m] = 1'b1;
              trip_f[m] = 1'b0;
              armed_spd[m] = p.speed_rpm16;
            end
          end
        end
      end
    end
    r.error_count = fault_run[m];
    r.settle_count = clean_run[m];
    r.armed = armed_f[m];
    r.tripped = trip_f[m];
    return r;
  endfunction

  function automatic msfv_pkg::poll_t mk(int m, logic [31:0] pulse, logic [31:0] pos,
                                         logic [23:0] per, logic [15:0] spd, bit pv,
                                         logic [23:0] mean, logic [23:0] sig,
                                         logic [9:0] load);
    msfv_pkg::poll_t p;
    p.motor_index = 2'(m);
    p.pulse_count = pulse;
    p.step_position = pos;
    p.period_us = per;
    p.speed_rpm16 = spd;
    p.profile_valid = pv;
    p.profile_mean_us = mean;
    p.profile_sigma_us = sig;
    p.stall_load = load;
    return p;
  endfunction

  function automatic msfv_pkg::poll_t rand_poll();
    msfv_pkg::poll_t p;
    int m, k, sg;
    logic [23:0] mean, sig;
    bit bad;
    if ($urandom_range(0, 99) < 12) begin
      p.motor_index = 2'($urandom);
      p.pulse_count = $urandom;
      p.step_position = $urandom;
      p.period_us = 24'($urandom);
      p.speed_rpm16 = 16'($urandom);
      p.profile_valid = 1'($urandom);
      p.profile_mean_us = 24'($urandom);
      p.profile_sigma_us = 24'($urandom);
      p.stall_load = 10'($urandom);
      return p;
    end
    m = $urandom_range(0, NMot - 1);
    bad = $urandom_range(0, 3) == 0;
    if ($urandom_range(0, 9) != 0) begin
      k = $urandom_range(1, 3);
      sg = ($urandom_range(0, 9) == 0) ? -1 : 1;
      trk_pulse[m] += k;
      trk_pos[m] += sg * k * int'(spr_reg);
      trk_pos[m] += bad ? int'(spr_reg) / 2 * k : $urandom_range(0, 200) - 100;
    end
    case ($urandom_range(0, 19))
      0: trk_speed[m] = 16'($urandom_range(0, 3300));
      1: trk_speed[m] = 16'($urandom);
      default: if (trk_speed[m] < 3200) trk_speed[m] = 16'($urandom_range(3200, 40000));
    endcase
    mean = 24'($urandom_range(1000, 200000));
    sig = 24'(mean / 20);
    p.motor_index = 2'(m);
    p.pulse_count = trk_pulse[m];
    p.step_position = trk_pos[m];
    p.speed_rpm16 = 16'(trk_speed[m] + $urandom_range(0, 60) - 30);
    p.profile_valid = $urandom_range(0, 9) != 0;
    p.profile_mean_us = mean;
    p.profile_sigma_us = sig;
    p.period_us = 24'(bad ? mean + 5 * sig : mean + $urandom_range(0, 6 * sig) - 3 * sig);
    p.stall_load = 10'((bad || $urandom_range(0, 4) == 0) ? $urandom_range(0, thresh_reg)
                                                            : $urandom_range(thresh_reg, 1023));
    return p;
  endfunction

  task automatic wait_idle();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [msfv_pkg::CfgIdxW-1:0] idx,
                           logic [msfv_pkg::CfgDataW-1:0] val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(idx, val);
  endtask

  // called at a rising edge; returns at the edge where the transaction happened
  task automatic send_poll(msfv_pkg::poll_t p, bit typed, msfv_pkg::result_t typed_res);
    msfv_pkg::result_t r;
    while (!quiet && $urandom_range(0, 99) < 11) begin
      poll_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    poll_if.valid <= 1'b1;
    poll_if.data <= p;
    do @(posedge clk_i); while (!poll_if.ready);
    r = vote(p);
    expected_q.push_back(typed ? typed_res : r);
  endtask

  // result side: random stalls and checking
  always @(posedge clk_i) begin
    msfv_pkg::result_t e, a;
    if (rst_ni && result_if.valid && result_if.ready) begin
      a = result_if.data;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %p", a);
        mismatches++;
      end else begin
        e = expected_q.pop_front();
        if (a.motor_out !== e.motor_out) begin
          $error("motor_out exp %0d got %0d", e.motor_out, a.motor_out); mismatches++;
        end
        if (a.evaluated !== e.evaluated) begin
          $error("evaluated exp %0d got %0d", e.evaluated, a.evaluated); mismatches++;
        end
        if (a.fault_code !== e.fault_code) begin
          $error("fault_code exp %0d got %0d", e.fault_code, a.fault_code); mismatches++;
        end
        if (a.error_count !== e.error_count) begin
          $error("error_count exp %0d got %0d", e.error_count, a.error_count); mismatches++;
        end
        if (a.settle_count !== e.settle_count) begin
          $error("settle_count exp %0d got %0d", e.settle_count, a.settle_count);
          mismatches++;
        end
        if (a.armed !== e.armed) begin
          $error("armed exp %0d got %0d", e.armed, a.armed); mismatches++;
        end
        if (a.tripped !== e.tripped) begin
          $error("tripped exp %0d got %0d", e.tripped, a.tripped); mismatches++;
        end
        if (a.stop_request !== e.stop_request) begin
          $error("stop_request exp %0d got %0d", e.stop_request, a.stop_request);
          mismatches++;
        end
        if (a.delta_per_pulse !== e.delta_per_pulse) begin
          $error("delta_per_pulse exp %0d got %0d", e.delta_per_pulse, a.delta_per_pulse);
          mismatches++;
        end
      end
    end
    result_if.ready <= rst_ni && (quiet || $urandom_range(0, 99) >= 11);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (poll_if.valid && poll_if.ready) || (result_if.valid && result_if.ready))
    begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  typedef struct {
    bit                            is_cfg;
    logic [msfv_pkg::CfgIdxW-1:0]  idx;
    logic [msfv_pkg::CfgDataW-1:0] val;
    msfv_pkg::poll_t               p;
    bit                            typed;
    msfv_pkg::result_t             res;
  } row_t;

  row_t rows[$];

  function automatic void add_poll(msfv_pkg::poll_t p);
    rows.push_back('{1'b0, '0, '0, p, 1'b0, '0});
  endfunction

  function automatic void add_typed(msfv_pkg::poll_t p, msfv_pkg::result_t r);
    rows.push_back('{1'b0, '0, '0, p, 1'b1, r});
  endfunction

  function automatic void add_cfg(logic [msfv_pkg::CfgIdxW-1:0] idx,
                                  logic [msfv_pkg::CfgDataW-1:0] val);
    rows.push_back('{1'b1, idx, val, '0, 1'b0, '0});
  endfunction

  function automatic msfv_pkg::result_t quiet_res(logic [1:0] m, logic [31:0] delta);
    msfv_pkg::result_t r;
    r = '0;
    r.motor_out = m;
    r.delta_per_pulse = delta;
    return r;
  endfunction

  initial begin
    int ph;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    poll_if.valid = 1'b0;
    poll_if.data = '0;
    quiet = 1'b0;
    for (int m = 0; m < NMot; m++) begin
      trk_pulse[m] = '0;
      trk_pos[m] = '0;
      trk_speed[m] = 16'd16000;
    end
    reset_model();
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: disabled poll, baseline with divide overflow, arm, trip, corners
    add_typed(mk(0, 1, 3200, 1000, 16000, 1, 1000, 10, 500), quiet_res(0, 0));
    add_cfg(msfv_pkg::RegLoadThreshold, 100);
    add_cfg(msfv_pkg::RegEnableMask, 16'hF);
    add_typed(mk(0, 1, 3200, 1000, 16000, 1, 1000, 10, 500), quiet_res(0, 3200));
    add_typed(mk(1, 32'hFFFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0, 0),
              quiet_res(1, 32'h7FFF_FFFF));
    for (int i = 2; i <= 6; i++) add_poll(mk(0, i, 3200 * i, 1000, 16000, 1, 1000, 10, 500));
    add_poll(mk(0, 6, 0, 1000, 16000, 1, 1000, 10, 500));
    for (int i = 7; i <= 9; i++)
      add_poll(mk(0, i, 19200 + 6400 * (i - 6), 2000, 16000, 1, 1000, 10, 500));
    add_poll(mk(0, 10, 45000, 1000, 100, 1, 1000, 10, 500));
    add_poll(mk(2, 32'h8000_0000, 32'h7FFF_FFFF, 1000, 16000, 1, 1000, 10, 500));
    add_poll(mk(2, 0, 32'h8000_0000, 1000, 16000, 1, 1000, 10, 50));
    add_poll(mk(3, 5, 32'h7FFF_FFFF, 24'hFFFFFF, 16'hFFFF, 1, 0, 24'hFFFFFF, 10'h3FF));
    add_poll(mk(3, 6, 0, 0, 16'hFFFF, 1, 24'hFFFFFF, 0, 0));
    add_cfg(msfv_pkg::RegStepsPerRev, 0);
    add_poll(mk(3, 7, 3200, 0, 16'hFFFF, 0, 0, 0, 0));
    add_cfg(msfv_pkg::RegStepsPerRev, 16'hFFFF);
    add_cfg(RegSpare, 16'hFFFF);
    add_cfg(msfv_pkg::RegEnableMask, 0);
    add_typed(mk(1, 9, 9, 9, 16000, 0, 0, 0, 0), quiet_res(1, 0));

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        poll_if.valid <= 1'b0;
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        send_poll(rows[i].p, rows[i].typed, rows[i].res);
      end
    end

    // random: well-formed per-motor sequences with noise, settings changed per phase
    ph = 0;
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 250 == 0) begin
        poll_if.valid <= 1'b0;
        write_reg(msfv_pkg::RegStepsPerRev, SprSet[ph % 6]);
        write_reg(msfv_pkg::RegLoadThreshold, 16'(ThrSet[ph % 6]));
        write_reg(msfv_pkg::RegEnableMask,
                  (ph % 3 == 2) ? 16'($urandom_range(0, 15)) : 16'hF);
        for (int m = 0; m < NMot; m++) trk_pos[m] = $urandom;
        ph++;
      end
      quiet = (i >= 500 && i < 800);
      send_poll(rand_poll(), 1'b0, '0);
    end
    poll_if.valid <= 1'b0;
    quiet = 1'b0;
    wait_idle();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
